// ----- rtl/core/bcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked cartridge mapper package
// Shared types, codes and constants for the mapper, its control registers
// and its clock-word unit.
// ----------------------------------------------------------------------------
package bcm_pkg;

	localparam int ROM_BANK_BYTES = 16384;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
	localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
	localparam int ROM_BANK_W     = 7;
	localparam int RAM_BANK_W     = 4;
	localparam int MEM_ADDR_W     = 21;
	localparam int CLOCK_W        = 28;
	localparam int NIB_COUNT      = CLOCK_W / 4;
	localparam int PTR_W          = 5;

	localparam logic [PTR_W-1:0]   PTR_LAST        = 5'd24;
	localparam logic [PTR_W-1:0]   PTR_STEP        = 5'd4;
	localparam logic [11:0]        MINUTES_PER_DAY = 12'd1440;
	localparam logic [11:0]        DAYS_PER_YEAR   = 12'd365;
	localparam logic [CLOCK_W-1:0] DAY_CARRY       = 28'h0001000 - 28'd1440;
	localparam logic [CLOCK_W-1:0] YEAR_CARRY      = 28'h1000000 - (28'd365 << 12);

	// Mode byte codes
	localparam logic [7:0] MODE_RAM_IDLE = 8'h00;
	localparam logic [7:0] MODE_RAM      = 8'h0A;
	localparam logic [7:0] MODE_CLK_CMD  = 8'h0B;
	localparam logic [7:0] MODE_LATCH    = 8'h0C;
	localparam logic [7:0] MODE_ONE      = 8'h0D;
	localparam logic [7:0] RAM_EN_MASK   = 8'h0A;

	// Clock command codes (high nibble of the data byte)
	localparam logic [3:0] CMD_NIB_READ  = 4'h1;
	localparam logic [3:0] CMD_NIB_WRITE = 4'h3;
	localparam logic [3:0] CMD_NORMALIZE = 4'h4;
	localparam logic [3:0] CMD_LATCH_ONE = 4'h6;

	// Low nibbles of a normalize command that also rewind the pointer
	localparam logic [3:0] NORM_RW_A = 4'h0;
	localparam logic [3:0] NORM_RW_B = 4'h3;
	localparam logic [3:0] NORM_RW_C = 4'h7;

	typedef enum logic [1:0] {
		TGT_NONE   = 2'd0,
		TGT_ROM_RD = 2'd1,
		TGT_RAM_RD = 2'd2,
		TGT_RAM_WR = 2'd3
	} target_t;

	typedef struct packed {
		logic        action;
		logic [15:0] address;
		logic [7:0]  write_data;
	} acc_t;

	typedef struct packed {
		target_t                 target;
		logic [MEM_ADDR_W-1:0]   mem_address;
		logic [7:0]              read_value;
	} res_t;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} clk_cmd_t;

endpackage

// ----- rtl/core/bcm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mapper channel interfaces
// Valid/ready channels for bus access beats and result beats.
// ----------------------------------------------------------------------------
interface bcm_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, output action, output address, output write_data,
		input ready);
	modport sink (input valid, input action, input address, input write_data,
		output ready);
endinterface

interface bcm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  target;
	logic [20:0] mem_address;
	logic [7:0]  read_value;

	modport source (output valid, output target, output mem_address, output read_value,
		input ready);
	modport sink (input valid, input target, input mem_address, input read_value,
		output ready);
endinterface

// ----- rtl/core/bcm_rtc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock-word unit
// Holds the 28-bit clock word, nibble pointer and value latch; runs
// clock commands.
// ----------------------------------------------------------------------------
module bcm_rtc (
	input  logic              clk,
	input  logic              arst_n,
	input  bcm_pkg::clk_cmd_t cmd,
	output logic [7:0]        latch
);

	logic [bcm_pkg::CLOCK_W-1:0] clock_q, clock_d, norm1, norm2;
	logic [bcm_pkg::PTR_W-1:0]   ptr_q, ptr_d;
	logic [7:0]                  latch_q, latch_d;
	logic [2:0]                  nib;
	logic [3:0]                  op, lo;
	logic                        ptr_ok;

	assign op     = cmd.data[7:4];
	assign lo     = cmd.data[3:0];
	assign nib    = ptr_q[4:2];
	assign ptr_ok = (ptr_q <= bcm_pkg::PTR_LAST);
	assign latch  = latch_q;

	// Carry one day, then one year; year field wraps at the word width
	always_comb begin
		norm1 = clock_q;
		if (clock_q[11:0] >= bcm_pkg::MINUTES_PER_DAY) begin
			norm1 = clock_q + bcm_pkg::DAY_CARRY;
		end
		norm2 = norm1;
		if (norm1[23:12] >= bcm_pkg::DAYS_PER_YEAR) begin
			norm2 = norm1 + bcm_pkg::YEAR_CARRY;
		end
	end

	always_comb begin
		clock_d = clock_q;
		ptr_d   = ptr_q;
		latch_d = latch_q;
		if (cmd.en) begin
			case (op)
				bcm_pkg::CMD_NIB_READ: begin
					if (ptr_ok) begin
						latch_d = {4'h0, clock_q[{nib, 2'b00} +: 4]};
						ptr_d   = ptr_q + bcm_pkg::PTR_STEP;
					end
				end
				bcm_pkg::CMD_NIB_WRITE: begin
					if (ptr_ok) begin
						for (int i = 0; i < bcm_pkg::NIB_COUNT; i++) begin
							if (nib == 3'(i)) begin
								clock_d[i*4 +: 4] = lo;
							end
						end
						ptr_d = ptr_q + bcm_pkg::PTR_STEP;
					end
				end
				bcm_pkg::CMD_NORMALIZE: begin
					clock_d = norm2;
					if (lo == bcm_pkg::NORM_RW_A || lo == bcm_pkg::NORM_RW_B ||
						lo == bcm_pkg::NORM_RW_C) begin
						ptr_d = '0;
					end
				end
				bcm_pkg::CMD_LATCH_ONE: begin
					latch_d = 8'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			ptr_q   <= '0;
			latch_q <= '0;
		end else begin
			clock_q <= clock_d;
			ptr_q   <= ptr_d;
			latch_q <= latch_d;
		end
	end

endmodule

// ----- rtl/core/bcm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mapper control and address decode
// Holds bank, enable and mode registers; maps one access to its result.
// ----------------------------------------------------------------------------
module bcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  bcm_pkg::acc_t     acc,
	input  logic              fire,
	input  logic [7:0]        latch,
	output bcm_pkg::res_t     res,
	output bcm_pkg::clk_cmd_t cmd
);

	logic [bcm_pkg::ROM_BANK_W-1:0] rom_bank_q;
	logic [bcm_pkg::RAM_BANK_W-1:0] ram_bank_q;
	logic                           ram_en_q;
	logic [7:0]                     mode_q;
	logic [3:0]                     region;
	logic                           ram_win;
	logic [bcm_pkg::MEM_ADDR_W-1:0] ram_addr;
	logic [bcm_pkg::ROM_BANK_W-1:0] new_rom_bank;

	assign region  = acc.address[15:12];
	assign ram_win = (region == 4'hA) || (region == 4'hB);
	assign ram_addr = bcm_pkg::MEM_ADDR_W'({ram_bank_q, acc.address[bcm_pkg::RAM_OFS_W-1:0]});
	assign new_rom_bank = (acc.write_data[6:0] == '0) ? 7'd1 : acc.write_data[6:0];

	always_comb begin
		res.target      = bcm_pkg::TGT_NONE;
		res.mem_address = '0;
		res.read_value  = '0;
		cmd.en          = 1'b0;
		cmd.data        = acc.write_data;
		if (!acc.action) begin
			res.read_value = 8'hFF;
			if (region <= 4'd3) begin
				res.target      = bcm_pkg::TGT_ROM_RD;
				res.mem_address = bcm_pkg::MEM_ADDR_W'(acc.address);
				res.read_value  = '0;
			end else if (region <= 4'd7) begin
				res.target      = bcm_pkg::TGT_ROM_RD;
				res.mem_address = {rom_bank_q, acc.address[bcm_pkg::ROM_OFS_W-1:0]};
				res.read_value  = '0;
			end else if (ram_win) begin
				if (mode_q == bcm_pkg::MODE_RAM_IDLE || mode_q == bcm_pkg::MODE_RAM) begin
					if (ram_en_q) begin
						res.target      = bcm_pkg::TGT_RAM_RD;
						res.mem_address = ram_addr;
						res.read_value  = '0;
					end
				end else if (mode_q == bcm_pkg::MODE_LATCH) begin
					res.read_value = latch;
				end else if (mode_q == bcm_pkg::MODE_ONE) begin
					res.read_value = 8'd1;
				end
			end
		end else if (ram_win) begin
			if (mode_q == bcm_pkg::MODE_CLK_CMD) begin
				cmd.en = fire;
			end else if (mode_q == bcm_pkg::MODE_RAM && ram_en_q) begin
				res.target      = bcm_pkg::TGT_RAM_WR;
				res.mem_address = ram_addr;
			end
		end
	end

	// Register writes take effect as the beat leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 7'd1;
			ram_bank_q <= '0;
			ram_en_q   <= 1'b0;
			mode_q     <= '0;
		end else if (fire && acc.action) begin
			if (region <= 4'd1) begin
				mode_q   <= acc.write_data;
				ram_en_q <= |(acc.write_data & bcm_pkg::RAM_EN_MASK);
			end else if (region <= 4'd3) begin
				rom_bank_q <= new_rom_bank;
			end else if (region <= 4'd5) begin
				ram_bank_q <= acc.write_data[bcm_pkg::RAM_BANK_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/core/banked_cartridge_mapper_with_rtc_unit.sv -----
`timescale 1ns / 1ps
// Path: an accepted access beat is registered in the input stage, then in the result register.
// Throughput: one access per cycle, sustained while the result side takes beats.
// The rate is set by the combinational decode/update between the input stage
// and the result register; all mapper state is read and written as a beat advances.
// Reset: asynchronous, active low; ROM bank to 1, all other mapper state to 0,
// both stages empty.
// ----------------------------------------------------------------------------
// Banked cartridge mapper with clock word
// Maps CPU bus accesses onto ROM/RAM banks and runs clock-word commands.
// ----------------------------------------------------------------------------
module banked_cartridge_mapper_with_rtc_unit (
	input logic       clk,
	input logic       arst_n,
	bcm_req_if.sink   req,
	bcm_rsp_if.source rsp
);

	bcm_pkg::acc_t     acc_s1;
	logic              valid_s1;
	logic              out_valid_q;
	bcm_pkg::res_t     res, res_q;
	bcm_pkg::clk_cmd_t cmd;
	logic [7:0]        latch;
	logic              advance;

	// Move the staged beat into the result register when that register is
	// free or being emptied this cycle; all state updates ride on this.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage: hold until the next beat is taken
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			acc_s1.action     <= req.action;
			acc_s1.address    <= req.address;
			acc_s1.write_data <= req.write_data;
		end
	end

	bcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_s1),
		.fire   (advance),
		.latch  (latch),
		.res    (res),
		.cmd    (cmd)
	);

	bcm_rtc u_rtc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.latch  (latch)
	);

	// Result register: valid drops only once the beat is taken and nothing
	// new arrives behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.target      = res_q.target;
	assign rsp.mem_address = res_q.mem_address;
	assign rsp.read_value  = res_q.read_value;

endmodule

// ----- tb/banked_cartridge_mapper_with_rtc_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked cartridge mapper testbench
// Sends CPU bus access beats into the mapper and checks every result beat
// against an in-bench model of the bank registers, mode byte, value latch
// and clock word. A short directed pass covers the edge cases, then random
// sessions (clock commands, RAM traffic, ROM banking, register reads and
// noise) run with random gaps on both channels.
// ----------------------------------------------------------------------------
module banked_cartridge_mapper_with_rtc_unit_tb;

	localparam int CLK_HALF        = 6;
	localparam int RANDOM_ACCESSES = 1000;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 6;
	localparam int REPORT_LIMIT    = 10;

	// 8 KB windows of the bus, selected by address[15:13]
	localparam logic [2:0] WIN_MODE     = 3'b000;
	localparam logic [2:0] WIN_ROM_BANK = 3'b001;
	localparam logic [2:0] WIN_RAM_BANK = 3'b010;
	localparam logic [2:0] WIN_RAM      = 3'b101;
	// 16 KB ROM quarters, selected by address[15:14]
	localparam logic [1:0] QTR_ROM_FIXED  = 2'b00;
	localparam logic [1:0] QTR_ROM_BANKED = 2'b01;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// ------------------------------------------------------------------------
	// Model of the mapper state plus the queue of results still owed.
	// Every accepted access beat is mapped here in acceptance order; every
	// result beat pops the oldest entry and is compared field by field.
	// ------------------------------------------------------------------------
	class bank_map_scoreboard;
		logic [bcm_pkg::ROM_BANK_W-1:0] rom_bank    = 7'd1;
		logic [bcm_pkg::RAM_BANK_W-1:0] ram_bank    = '0;
		logic                           ram_enable  = 1'b0;
		logic [7:0]                     mode_byte   = '0;
		logic [7:0]                     value_latch = '0;
		logic [bcm_pkg::CLOCK_W-1:0]    clock_word  = '0;
		logic [bcm_pkg::PTR_W-1:0]      nib_ptr     = '0;
		bcm_pkg::res_t                  due_results[$];
		int                             mismatch_count = 0;

		function void run_clock_command(logic [7:0] data);
			case (data[7:4])
				bcm_pkg::CMD_NIB_READ: begin
					if (nib_ptr <= bcm_pkg::PTR_LAST) begin
						value_latch = {4'h0, clock_word[nib_ptr +: 4]};
						nib_ptr     = nib_ptr + bcm_pkg::PTR_STEP;
					end
				end
				bcm_pkg::CMD_NIB_WRITE: begin
					if (nib_ptr <= bcm_pkg::PTR_LAST) begin
						clock_word[nib_ptr +: 4] = data[3:0];
						nib_ptr                  = nib_ptr + bcm_pkg::PTR_STEP;
					end
				end
				bcm_pkg::CMD_NORMALIZE: begin
					// carry at most one day, then at most one year; years wrap
					if (clock_word[11:0] >= bcm_pkg::MINUTES_PER_DAY)
						clock_word = clock_word + bcm_pkg::DAY_CARRY;
					if (clock_word[23:12] >= bcm_pkg::DAYS_PER_YEAR)
						clock_word = clock_word + bcm_pkg::YEAR_CARRY;
					if (data[3:0] == bcm_pkg::NORM_RW_A || data[3:0] == bcm_pkg::NORM_RW_B ||
							data[3:0] == bcm_pkg::NORM_RW_C)
						nib_ptr = '0;
				end
				bcm_pkg::CMD_LATCH_ONE: value_latch = 8'd1;
				default: ;
			endcase
		endfunction

		function bcm_pkg::res_t map_access(bcm_pkg::acc_t a);
			bcm_pkg::res_t r;
			r.target      = bcm_pkg::TGT_NONE;
			r.mem_address = '0;
			r.read_value  = '0;
			if (a.action == ACT_READ) begin
				r.read_value = 8'hFF;
				if (a.address[15:14] == QTR_ROM_FIXED) begin
					r.target      = bcm_pkg::TGT_ROM_RD;
					r.mem_address = bcm_pkg::MEM_ADDR_W'(a.address);
					r.read_value  = '0;
				end else if (a.address[15:14] == QTR_ROM_BANKED) begin
					r.target      = bcm_pkg::TGT_ROM_RD;
					r.mem_address = bcm_pkg::MEM_ADDR_W'({rom_bank,
						a.address[bcm_pkg::ROM_OFS_W-1:0]});
					r.read_value  = '0;
				end else if (a.address[15:13] == WIN_RAM) begin
					if (mode_byte == bcm_pkg::MODE_RAM_IDLE || mode_byte == bcm_pkg::MODE_RAM) begin
						if (ram_enable) begin
							r.target      = bcm_pkg::TGT_RAM_RD;
							r.mem_address = bcm_pkg::MEM_ADDR_W'({ram_bank,
								a.address[bcm_pkg::RAM_OFS_W-1:0]});
							r.read_value  = '0;
						end
					end else if (mode_byte == bcm_pkg::MODE_LATCH) begin
						r.read_value = value_latch;
					end else if (mode_byte == bcm_pkg::MODE_ONE) begin
						r.read_value = 8'd1;
					end
				end
			end else begin
				case (a.address[15:13])
					WIN_MODE: begin
						mode_byte  = a.write_data;
						ram_enable = (a.write_data & bcm_pkg::RAM_EN_MASK) != 0;
					end
					WIN_ROM_BANK: begin
						rom_bank = (a.write_data[6:0] == '0) ? 7'd1 : a.write_data[6:0];
					end
					WIN_RAM_BANK: ram_bank = a.write_data[bcm_pkg::RAM_BANK_W-1:0];
					WIN_RAM: begin
						if (mode_byte == bcm_pkg::MODE_CLK_CMD) begin
							run_clock_command(a.write_data);
						end else if (mode_byte == bcm_pkg::MODE_RAM && ram_enable) begin
							r.target      = bcm_pkg::TGT_RAM_WR;
							r.mem_address = bcm_pkg::MEM_ADDR_W'({ram_bank,
								a.address[bcm_pkg::RAM_OFS_W-1:0]});
						end
					end
					default: ;
				endcase
			end
			return r;
		endfunction

		function void note_access(bcm_pkg::acc_t a);
			due_results.push_back(map_access(a));
		endfunction

		function void check_result(bcm_pkg::res_t got);
			bcm_pkg::res_t want;
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: result beat with nothing due: target=%0d mem=%h val=%h",
						got.target, got.mem_address, got.read_value);
				return;
			end
			want = due_results.pop_front();
			if (got.target !== want.target || got.mem_address !== want.mem_address ||
					got.read_value !== want.read_value) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: exp target=%0d mem=%h val=%h, got target=%0d mem=%h val=%h",
						want.target, want.mem_address, want.read_value,
						got.target, got.mem_address, got.read_value);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bcm_req_if req_ch ();
	bcm_rsp_if rsp_ch ();

	banked_cartridge_mapper_with_rtc_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bank_map_scoreboard sb = new;

	// calm phases: no gaps on either channel
	bit calm = 1'b0;
	int accesses_sent = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(99, 0);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(20, 4);
	endfunction

	function automatic logic [15:0] ram_window_addr();
		return 16'($urandom_range(16'hBFFF, 16'hA000));
	endfunction

	// Call at a falling edge; return at the falling edge after acceptance.
	// Keep valid high across back-to-back beats so it sees one assignment per step.
	task automatic send_access(input logic act, input logic [15:0] adr,
			input logic [7:0] dat);
		bcm_pkg::acc_t beat;
		int            gap;
		beat.action     = act;
		beat.address    = adr;
		beat.write_data = dat;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.address    <= adr;
		req_ch.write_data <= dat;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_access(beat);
		accesses_sent++;
		@(negedge clk);
	endtask

	task automatic set_mode(input logic [7:0] mode);
		send_access(ACT_WRITE, 16'($urandom_range(16'h1FFF, 16'h0000)), mode);
	endtask

	// Result side: random stalls, released at falling edges.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall_left = ($urandom_range(3, 0) == 0) ? pick_gap() : 0;
				rsp_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Sample result beats at the rising edge.
	initial begin
		bcm_pkg::res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.target      = bcm_pkg::target_t'(rsp_ch.target);
				got.mem_address = rsp_ch.mem_address;
				got.read_value  = rsp_ch.read_value;
				sb.check_result(got);
			end
		end
	end

	// Abort when no beat moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ERROR: watchdog expired, %0d results still due", sb.due_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int          n;
		int          target_count;
		logic [3:0]  cmd;
		logic [3:0]  lo;
		logic [15:0] adr;

		req_ch.valid      <= 1'b0;
		req_ch.action     <= ACT_READ;
		req_ch.address    <= '0;
		req_ch.write_data <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed pass ----
		send_access(ACT_READ,  16'h0000, 8'h00);   // fixed ROM, address passes through
		send_access(ACT_READ,  16'hA000, 8'h5A);   // RAM disabled after reset: 0xFF
		send_access(ACT_READ,  16'hFFFF, 8'hFF);   // unmapped read: 0xFF
		send_access(ACT_WRITE, 16'h2000, 8'h00);   // ROM bank 0 is stored as 1
		send_access(ACT_READ,  16'h4000, 8'h00);
		send_access(ACT_WRITE, 16'h3FFF, 8'hFF);   // top ROM bank 0x7F
		send_access(ACT_READ,  16'h7FFF, 8'h00);
		send_access(ACT_WRITE, 16'h5FFF, 8'hFF);   // top RAM bank
		set_mode(bcm_pkg::MODE_RAM);
		send_access(ACT_WRITE, 16'hBFFF, 8'hFF);   // RAM write at top of top bank
		send_access(ACT_READ,  16'hA000, 8'h00);   // RAM read
		set_mode(bcm_pkg::MODE_CLK_CMD);
		// load 1440 minutes, 364 days, year 15 one nibble at a time
		send_access(ACT_WRITE, 16'hA000, {bcm_pkg::CMD_NIB_WRITE, 4'h0});
		send_access(ACT_WRITE, 16'hA001, {bcm_pkg::CMD_NIB_WRITE, 4'hA});
		send_access(ACT_WRITE, 16'hA002, {bcm_pkg::CMD_NIB_WRITE, 4'h5});
		send_access(ACT_WRITE, 16'hA003, {bcm_pkg::CMD_NIB_WRITE, 4'hC});
		send_access(ACT_WRITE, 16'hA004, {bcm_pkg::CMD_NIB_WRITE, 4'h6});
		send_access(ACT_WRITE, 16'hA005, {bcm_pkg::CMD_NIB_WRITE, 4'h1});
		send_access(ACT_WRITE, 16'hBFFF, {bcm_pkg::CMD_NIB_WRITE, 4'hF});
		// pointer exhausted
		send_access(ACT_WRITE, 16'hA000, {bcm_pkg::CMD_NIB_WRITE, 4'h9});
		send_access(ACT_WRITE, 16'hA000, {bcm_pkg::CMD_NIB_READ, 4'h0});
		// day carry forces year carry; year field wraps to zero; rewind pointer
		send_access(ACT_WRITE, 16'hA000, {bcm_pkg::CMD_NORMALIZE, bcm_pkg::NORM_RW_A});
		send_access(ACT_WRITE, 16'hA000, {bcm_pkg::CMD_LATCH_ONE, 4'h0});
		send_access(ACT_WRITE, 16'h6000, 8'hFF);   // unmapped write: ignored
		set_mode(bcm_pkg::MODE_LATCH);
		send_access(ACT_READ,  16'hB000, 8'h00);   // latch holds 1
		set_mode(8'hFF);
		send_access(ACT_READ,  16'hA123, 8'h00);   // unknown mode: 0xFF

		// ---- random sessions ----
		n = accesses_sent + RANDOM_ACCESSES;
		while (accesses_sent < n) begin
			if ($urandom_range(7, 0) == 0)
				calm = ~calm;
			case ($urandom_range(9, 0))
				0, 1: begin
					// noise: fully random beats
					repeat ($urandom_range(4, 1))
						send_access(1'($urandom), 16'($urandom), 8'($urandom));
				end
				2, 3, 4: begin
					// clock command burst, then most of the time look at the latch
					set_mode(bcm_pkg::MODE_CLK_CMD);
					repeat ($urandom_range(12, 3)) begin
						lo = 4'($urandom);
						case ($urandom_range(7, 0))
							0, 1: cmd = bcm_pkg::CMD_NIB_READ;
							2, 3, 4: cmd = bcm_pkg::CMD_NIB_WRITE;
							5: begin
								cmd = bcm_pkg::CMD_NORMALIZE;
								if ($urandom_range(1, 0) == 0)
									case ($urandom_range(2, 0))
										0: lo = bcm_pkg::NORM_RW_A;
										1: lo = bcm_pkg::NORM_RW_B;
										default: lo = bcm_pkg::NORM_RW_C;
									endcase
							end
							6: cmd = bcm_pkg::CMD_LATCH_ONE;
							default: cmd = 4'($urandom);
						endcase
						if ($urandom_range(9, 0) == 0)
							send_access(ACT_READ, ram_window_addr(), 8'($urandom));
						send_access(ACT_WRITE, ram_window_addr(), {cmd, lo});
					end
					if ($urandom_range(3, 0) != 0) begin
						set_mode(bcm_pkg::MODE_LATCH);
						repeat ($urandom_range(2, 1))
							send_access(ACT_READ, ram_window_addr(), 8'($urandom));
					end
				end
				5, 6: begin
					// RAM traffic under a random bank and a RAM-ish mode byte
					send_access(ACT_WRITE, 16'($urandom_range(16'h5FFF, 16'h4000)),
						8'($urandom));
					set_mode(($urandom_range(3, 0) != 0) ? bcm_pkg::MODE_RAM : 8'($urandom));
					repeat ($urandom_range(8, 2))
						send_access(1'($urandom), ram_window_addr(), 8'($urandom));
				end
				7, 8: begin
					// ROM banking; bank zero now and then
					send_access(ACT_WRITE, 16'($urandom_range(16'h3FFF, 16'h2000)),
						($urandom_range(4, 0) == 0) ? {1'($urandom), 7'h00} : 8'($urandom));
					repeat ($urandom_range(6, 1)) begin
						adr = 16'($urandom_range(16'h7FFF, 16'h0000));
						send_access(ACT_READ, adr, 8'($urandom));
					end
				end
				default: begin
					// register-sourced reads under assorted modes
					case ($urandom_range(3, 0))
						0: set_mode(bcm_pkg::MODE_LATCH);
						1: set_mode(bcm_pkg::MODE_ONE);
						2: set_mode(bcm_pkg::MODE_RAM_IDLE);
						default: set_mode(8'($urandom));
					endcase
					repeat ($urandom_range(4, 1)) begin
						adr = ($urandom_range(2, 0) == 0) ?
							16'($urandom_range(16'hFFFF, 16'h8000)) : ram_window_addr();
						send_access(ACT_READ, adr, 8'($urandom));
					end
				end
			endcase
		end
		req_ch.valid <= 1'b0;

		// wait out every owed result, then the pipeline latency
		while (sb.due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		target_count = sb.mismatch_count + sb.due_results.size();
		if (target_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/bcm_pkg.sv
rtl/core/bcm_if.sv
rtl/core/bcm_rtc.sv
rtl/core/bcm_ctrl.sv
rtl/core/banked_cartridge_mapper_with_rtc_unit.sv
tb/banked_cartridge_mapper_with_rtc_unit_tb.sv
